// ===== sv/ghrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Grant handshake retry controller package
// Shared command and action codes, register indexes, reset values and the
// structs that pass between the top level and the event step logic.
// ----------------------------------------------------------------------------
package ghrc_pkg;

    // Default width of the epoch counter.
    localparam int EPOCH_BITS_DEFAULT = 16;

    // Field widths fixed by the interface.
    localparam int TIME_W     = 63;
    localparam int TIMEOUT_W  = 40;
    localparam int ATTEMPT_W  = 8;
    localparam int TAG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS     = 2'd1;

    // Configuration reset values.
    localparam logic [TIMEOUT_W-1:0] RESPONSE_TIMEOUT_RESET = 40'd1000000000;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RESET     = 8'd3;

    // Event commands; codes six and seven mean nothing.
    typedef enum logic [2:0] {
        CMD_ACTIVATE     = 3'd0,
        CMD_DEACTIVATE   = 3'd1,
        CMD_INVALIDATE   = 3'd2,
        CMD_TICK         = 3'd3,
        CMD_REQUEST_SENT = 3'd4,
        CMD_REPLY        = 3'd5
    } cmd_t;

    // Result actions.
    typedef enum logic [3:0] {
        ACT_NONE          = 4'd0,
        ACT_STOP_TIMER    = 4'd1,
        ACT_WAIT          = 4'd2,
        ACT_GIVE_UP       = 4'd3,
        ACT_SEND_REQUEST  = 4'd4,
        ACT_IGNORE        = 4'd5,
        ACT_RELEASE_STALE = 4'd6,
        ACT_REFUSED       = 4'd7,
        ACT_REVOKED       = 4'd8,
        ACT_GRANTED       = 4'd9
    } action_t;

    // One input word.
    typedef struct packed {
        cmd_t              command;
        logic              handshake_required;
        logic [TIME_W-1:0] event_time;
        logic [TAG_W-1:0]  reply_epoch;
        logic              reply_enable;
        logic              reply_success;
    } item_t;

    // Handshake flags and the attempt counter.
    typedef struct packed {
        logic                 reply_pending;
        logic                 gave_up;
        logic                 grant_held;
        logic [ATTEMPT_W-1:0] attempt_count;
    } flags_t;

    // One result word.
    typedef struct packed {
        action_t          action;
        logic             timed_out;
        logic             prior_grant;
        logic [TAG_W-1:0] current_epoch;
    } result_t;

endpackage

// ===== sv/grant_handshake_retry_controller.sv =====
// ----------------------------------------------------------------------------
// Grant handshake retry controller
// Tracks a grant request handshake with epochs, timeouts and retries.
// ----------------------------------------------------------------------------
// Each accepted event word is held in an input register, decoded against the
// controller state and written to a result register, so one word is taken per
// clock while the result side keeps up; the state update and the 64-bit elapsed
// time compare sit in that single decode stage. A result is presented from the
// result register once its event has passed the decode stage. Configuration
// writes are always ready and take effect at once; write them only while idle.
// ----------------------------------------------------------------------------
module grant_handshake_retry_controller #(
    parameter int EPOCH_BITS = ghrc_pkg::EPOCH_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ghrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ghrc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Event channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        command,
    input  logic                              handshake_required,
    input  logic [ghrc_pkg::TIME_W-1:0]       event_time,
    input  logic [ghrc_pkg::TAG_W-1:0]        reply_epoch,
    input  logic                              reply_enable,
    input  logic                              reply_success,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [3:0]                        action,
    output logic                              timed_out,
    output logic                              prior_grant,
    output logic [ghrc_pkg::TAG_W-1:0]        current_epoch
);

    logic                                in_valid_reg;
    ghrc_pkg::item_t                     item_reg;
    logic                                out_valid_reg;
    ghrc_pkg::result_t                   result_reg;
    logic [EPOCH_BITS-1:0]               epoch_reg;
    logic [EPOCH_BITS-1:0]               epoch_next;
    ghrc_pkg::flags_t                    flags_reg;
    ghrc_pkg::flags_t                    flags_next;
    logic [ghrc_pkg::TIME_W-1:0]         stamp_reg;
    logic                                stamp_load;
    logic [ghrc_pkg::TIMEOUT_W-1:0]      timeout_reg;
    logic [ghrc_pkg::ATTEMPT_W-1:0]      max_attempts_reg;
    ghrc_pkg::item_t                     item_in;
    ghrc_pkg::result_t                   result_next;
    logic                                advance;

    // Handshake control: the decode stage moves when the result slot frees.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Pack the incoming word.
    assign item_in.command            = ghrc_pkg::cmd_t'(command);
    assign item_in.handshake_required = handshake_required;
    assign item_in.event_time         = event_time;
    assign item_in.reply_epoch        = reply_epoch;
    assign item_in.reply_enable       = reply_enable;
    assign item_in.reply_success      = reply_success;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg      <= ghrc_pkg::RESPONSE_TIMEOUT_RESET;
            max_attempts_reg <= ghrc_pkg::MAX_ATTEMPTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ghrc_pkg::REG_RESPONSE_TIMEOUT:
                    timeout_reg <= cfg_data[ghrc_pkg::TIMEOUT_W-1:0];
                ghrc_pkg::REG_MAX_ATTEMPTS:
                    max_attempts_reg <= cfg_data[ghrc_pkg::ATTEMPT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    // Event decode.
    ghrc_step #(
        .EPOCH_BITS (EPOCH_BITS)
    ) u_step (
        .item             (item_reg),
        .epoch            (epoch_reg),
        .flags            (flags_reg),
        .stamp            (stamp_reg),
        .response_timeout (timeout_reg),
        .max_attempts     (max_attempts_reg),
        .epoch_next       (epoch_next),
        .flags_next       (flags_next),
        .stamp_load       (stamp_load),
        .result           (result_next)
    );

    // Controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= '0;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            epoch_reg <= epoch_next;
            flags_reg <= flags_next;
        end
    end

    // Request time stamp, read only while a reply is pending.
    always_ff @(posedge clk)
    begin
        if (advance && stamp_load)
        begin
            stamp_reg <= item_reg.event_time;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = result_reg.action;
    assign timed_out     = result_reg.timed_out;
    assign prior_grant   = result_reg.prior_grant;
    assign current_epoch = result_reg.current_epoch;

endmodule

// ===== sv/ghrc_step.sv =====
// ----------------------------------------------------------------------------
// Grant handshake event step
// Combinational next state and result for one event word, given the current
// epoch, flags, request stamp and configuration.
// ----------------------------------------------------------------------------
module ghrc_step #(
    parameter int EPOCH_BITS = ghrc_pkg::EPOCH_BITS_DEFAULT
) (
    input  ghrc_pkg::item_t                         item,
    input  logic [EPOCH_BITS-1:0]                   epoch,
    input  ghrc_pkg::flags_t                        flags,
    input  logic [ghrc_pkg::TIME_W-1:0]             stamp,
    input  logic [ghrc_pkg::TIMEOUT_W-1:0]          response_timeout,
    input  logic [ghrc_pkg::ATTEMPT_W-1:0]          max_attempts,
    output logic [EPOCH_BITS-1:0]                   epoch_next,
    output ghrc_pkg::flags_t                        flags_next,
    output logic                                    stamp_load,
    output ghrc_pkg::result_t                       result
);

    localparam int CMP_W = (EPOCH_BITS > ghrc_pkg::TAG_W) ? EPOCH_BITS : ghrc_pkg::TAG_W;

    logic [CMP_W-1:0]  epoch_wide;
    logic [CMP_W-1:0]  tag_wide;
    logic              tag_match;
    logic signed [63:0] elapsed;
    logic signed [63:0] limit;
    logic              overdue;
    logic [EPOCH_BITS-1:0] epoch_inc;

    // Full epoch against the reply tag, both zero extended.
    assign epoch_wide = CMP_W'(epoch);
    assign tag_wide   = CMP_W'(item.reply_epoch);
    assign tag_match  = (epoch_wide == tag_wide);
    assign epoch_inc  = epoch + EPOCH_BITS'(1);

    // Signed time since the request; an earlier time counts as waiting.
    assign elapsed = $signed({1'b0, item.event_time}) - $signed({1'b0, stamp});
    assign limit   = $signed({24'd0, response_timeout});
    assign overdue = (elapsed > limit);

    // Event decode.
    always_comb
    begin
        epoch_next         = epoch;
        flags_next         = flags;
        stamp_load         = 1'b0;
        result.action      = ghrc_pkg::ACT_NONE;
        result.timed_out   = 1'b0;
        result.prior_grant = 1'b0;
        unique case (item.command)
            ghrc_pkg::CMD_ACTIVATE:
            begin
                epoch_next               = epoch_inc;
                flags_next.reply_pending = 1'b0;
                flags_next.gave_up       = 1'b0;
                flags_next.attempt_count = '0;
                flags_next.grant_held    = !item.handshake_required;
            end
            ghrc_pkg::CMD_DEACTIVATE:
            begin
                epoch_next               = epoch_inc;
                flags_next.reply_pending = 1'b0;
                flags_next.grant_held    = 1'b0;
                result.prior_grant       = flags.grant_held;
            end
            ghrc_pkg::CMD_INVALIDATE:
            begin
                epoch_next = epoch_inc;
            end
            ghrc_pkg::CMD_TICK:
            begin
                if (flags.grant_held || flags.gave_up)
                begin
                    result.action = ghrc_pkg::ACT_STOP_TIMER;
                end
                else if (flags.reply_pending && !overdue)
                begin
                    result.action = ghrc_pkg::ACT_WAIT;
                end
                else
                begin
                    // A pending reply here is overdue: drop it and retry.
                    if (flags.reply_pending)
                    begin
                        result.timed_out         = 1'b1;
                        flags_next.reply_pending = 1'b0;
                    end
                    if (flags.attempt_count >= max_attempts)
                    begin
                        flags_next.gave_up = 1'b1;
                        result.action      = ghrc_pkg::ACT_GIVE_UP;
                    end
                    else
                    begin
                        flags_next.attempt_count = flags.attempt_count + 8'd1;
                        result.action            = ghrc_pkg::ACT_SEND_REQUEST;
                    end
                end
            end
            ghrc_pkg::CMD_REQUEST_SENT:
            begin
                flags_next.reply_pending = 1'b1;
                stamp_load               = 1'b1;
            end
            ghrc_pkg::CMD_REPLY:
            begin
                if (!tag_match)
                begin
                    result.action = (item.reply_enable && item.reply_success) ?
                                    ghrc_pkg::ACT_RELEASE_STALE : ghrc_pkg::ACT_IGNORE;
                end
                else
                begin
                    flags_next.reply_pending = 1'b0;
                    if (!item.reply_success)
                    begin
                        result.action = ghrc_pkg::ACT_REFUSED;
                    end
                    else if (!item.reply_enable)
                    begin
                        result.action = ghrc_pkg::ACT_REVOKED;
                    end
                    else
                    begin
                        flags_next.grant_held = 1'b1;
                        result.action         = ghrc_pkg::ACT_GRANTED;
                    end
                end
            end
            default:
            begin
                result.action = ghrc_pkg::ACT_NONE;
            end
        endcase
        result.current_epoch = ghrc_pkg::TAG_W'(epoch_next);
    end

endmodule
